### design/lspa_pkg.sv
// ----------------------------------------------------------------------------
// lspa_pkg
// Codes, register map and result type shared by the scan packet aligner.
// ----------------------------------------------------------------------------
package lspa_pkg;

  localparam int PACKET_BYTES = 5;
  localparam int ADDR_W       = 5;
  localparam int DATA_W       = 32;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_ARM     = 2'd1;
  localparam logic [1:0] OP_RESTART = 2'd2;
  localparam logic [1:0] OP_NOP     = 2'd3;

  localparam logic [1:0] MODE_IDLE  = 2'd0;
  localparam logic [1:0] MODE_READY = 2'd1;
  localparam logic [1:0] MODE_REC   = 2'd2;
  localparam logic [1:0] MODE_PROC  = 2'd3;

  localparam logic [2:0] PH_HOLD   = 3'd0;
  localparam logic [2:0] PH_FIND   = 3'd1;
  localparam logic [2:0] PH_OFFSET = 3'd2;
  localparam logic [2:0] PH_SKIP   = 3'd3;
  localparam logic [2:0] PH_RECORD = 3'd4;

  localparam logic [2:0] REG_WAIT_BYTES   = 3'd0;
  localparam logic [2:0] REG_SKIP_BYTES   = 3'd1;
  localparam logic [2:0] REG_FRAME_POINTS = 3'd2;
  localparam logic [2:0] REG_MIN_ANGLE    = 3'd3;
  localparam logic [2:0] REG_MAX_ANGLE    = 3'd4;

  localparam logic [15:0] WAIT_BYTES_RST   = 16'd256;
  localparam logic [7:0]  SKIP_BYTES_RST   = 8'd5;
  localparam logic [10:0] FRAME_POINTS_RST = 11'd1024;
  localparam logic [14:0] MIN_ANGLE_RST    = 15'd0;
  localparam logic [14:0] MAX_ANGLE_RST    = 15'd32767;

  localparam logic [1:0] START_MASK = 2'h3;
  localparam logic [1:0] START_ONE  = 2'h1;
  localparam logic [1:0] START_TWO  = 2'h2;

  typedef struct packed {
    logic        point_valid;
    logic [14:0] angle_raw;
    logic [15:0] distance_raw;
    logic [9:0]  point_index;
    logic        frame_done;
    logic        recording;
    logic [1:0]  mode;
  } res_t;

endpackage

### design/lspa_cmd_if.sv
// ----------------------------------------------------------------------------
// lspa_cmd_if
// Command channel: received byte, arm and restart requests.
// ----------------------------------------------------------------------------
interface lspa_cmd_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [7:0] rx_byte;

  modport source (output valid, output opcode, output rx_byte, input ready);
  modport sink   (input valid, input opcode, input rx_byte, output ready);
endinterface

### design/lspa_res_if.sv
// ----------------------------------------------------------------------------
// lspa_res_if
// Result channel: one status and point transfer per command.
// ----------------------------------------------------------------------------
interface lspa_res_if;
  logic        valid;
  logic        ready;
  logic        point_valid;
  logic [14:0] angle_raw;
  logic [15:0] distance_raw;
  logic [9:0]  point_index;
  logic        frame_done;
  logic        recording;
  logic [1:0]  mode;

  modport source (
    output valid, output point_valid, output angle_raw, output distance_raw,
    output point_index, output frame_done, output recording, output mode,
    input ready
  );
  modport sink (
    input valid, input point_valid, input angle_raw, input distance_raw,
    input point_index, input frame_done, input recording, input mode,
    output ready
  );
endinterface

### design/lidar_scan_packet_aligner.sv
// ----------------------------------------------------------------------------
// lidar_scan_packet_aligner
// Aligns a range-finder byte stream on packet boundaries and emits scan points.
// Results are registered; a two-entry output stage absorbs stalls.
// Throughput: one command per cycle while the skid entry is empty.
// Reset: synchronous; control state cleared, registers back to defaults.
// ----------------------------------------------------------------------------
module lidar_scan_packet_aligner
  import lspa_pkg::*;
#(
  parameter int WINDOW_BYTES = 20,
  parameter int MAX_POINTS   = 1024
) (
  input  logic              clk,
  input  logic              rst,
  lspa_cmd_if.sink          cmd,
  lspa_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  localparam int WIN_AW  = $clog2(WINDOW_BYTES);
  localparam int CNT_W   = $clog2(MAX_POINTS + 1);
  localparam int PACKETS = WINDOW_BYTES / PACKET_BYTES;

  // configuration
  logic [15:0] wait_bytes;
  logic [7:0]  skip_bytes;
  logic [10:0] frame_points;
  logic [14:0] min_angle;
  logic [14:0] max_angle;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wait_bytes   <= WAIT_BYTES_RST;
      skip_bytes   <= SKIP_BYTES_RST;
      frame_points <= FRAME_POINTS_RST;
      min_angle    <= MIN_ANGLE_RST;
      max_angle    <= MAX_ANGLE_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_WAIT_BYTES:   wait_bytes   <= pwdata[15:0];
        REG_SKIP_BYTES:   skip_bytes   <= pwdata[7:0];
        REG_FRAME_POINTS: frame_points <= pwdata[10:0];
        REG_MIN_ANGLE:    min_angle    <= pwdata[14:0];
        REG_MAX_ANGLE:    max_angle    <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_WAIT_BYTES:   prdata = {16'd0, wait_bytes};
      REG_SKIP_BYTES:   prdata = {24'd0, skip_bytes};
      REG_FRAME_POINTS: prdata = {21'd0, frame_points};
      REG_MIN_ANGLE:    prdata = {17'd0, min_angle};
      REG_MAX_ANGLE:    prdata = {17'd0, max_angle};
      default:          prdata = '0;
    endcase
  end

  // state
  logic [1:0]       run_mode, run_mode_next;
  logic [2:0]       phase, phase_next;
  logic [15:0]      byte_count, byte_count_next;
  logic [2:0]       align_offset, align_offset_next;
  logic [14:0]      pend_angle, pend_angle_next;
  logic [15:0]      pend_dist, pend_dist_next;
  logic             pending_flag, pending_flag_next;
  logic [CNT_W-1:0] stored_count, stored_count_next;
  logic             ignore_flag, ignore_flag_next;
  logic [7:0]       window [WINDOW_BYTES];

  logic              win_we;
  logic [WIN_AW-1:0] win_addr;
  logic [16:0]       n;
  logic [CNT_W-1:0]  limit;
  logic [7:0]        eff [WINDOW_BYTES];
  logic [4:0]        off_ok;
  logic              found;
  logic [2:0]        found_off;
  res_t              r;

  logic cmd_fire, res_fire;
  res_t out_data, skid_data;
  logic out_valid, skid_valid;

  assign cmd.ready = !skid_valid;
  assign cmd_fire  = cmd.valid && cmd.ready;
  assign res_fire  = out_valid && res.ready;

  always_comb begin
    if (32'(frame_points) < MAX_POINTS) begin
      limit = CNT_W'(frame_points);
    end else begin
      limit = CNT_W'(MAX_POINTS);
    end
  end

  // alignment search over the window, last byte taken from the bus
  always_comb begin
    int pos;
    logic ok;
    for (int i = 0; i < WINDOW_BYTES; i++) begin
      eff[i] = window[i];
    end
    eff[WINDOW_BYTES-1] = cmd.rx_byte;
    for (int off = 0; off < PACKET_BYTES; off++) begin
      off_ok[off] = 1'b1;
      for (int k = 0; k < PACKETS; k++) begin
        pos = off + k * PACKET_BYTES;
        ok  = 1'b1;
        if (pos + 1 < WINDOW_BYTES) begin
          ok = ((eff[pos][1:0] & START_MASK) == START_ONE
             || (eff[pos][1:0] & START_MASK) == START_TWO) && eff[pos+1][0];
        end
        off_ok[off] = off_ok[off] && ok;
      end
    end
    found     = 1'b0;
    found_off = '0;
    for (int off = PACKET_BYTES - 1; off >= 0; off--) begin
      if (off_ok[off]) begin
        found     = 1'b1;
        found_off = 3'(off);
      end
    end
  end

  always_comb begin
    logic in_range;
    run_mode_next     = run_mode;
    phase_next        = phase;
    byte_count_next   = byte_count;
    align_offset_next = align_offset;
    pend_angle_next   = pend_angle;
    pend_dist_next    = pend_dist;
    pending_flag_next = pending_flag;
    stored_count_next = stored_count;
    ignore_flag_next  = ignore_flag;
    win_we            = 1'b0;
    win_addr          = byte_count[WIN_AW-1:0];
    n                 = {1'b0, byte_count} + 17'd1;
    in_range          = 1'b0;
    r                 = '0;

    case (cmd.opcode)
      OP_ARM: begin
        if (run_mode == MODE_IDLE) run_mode_next = MODE_READY;
      end
      OP_RESTART: begin
        run_mode_next     = MODE_IDLE;
        phase_next        = PH_HOLD;
        byte_count_next   = '0;
        stored_count_next = '0;
        pending_flag_next = 1'b0;
        ignore_flag_next  = 1'b0;
      end
      OP_BYTE: begin
        case (phase)
          PH_FIND: begin
            win_we = 32'(byte_count) < WINDOW_BYTES;
            if (n < 17'(WINDOW_BYTES)) begin
              byte_count_next = n[15:0];
            end else begin
              byte_count_next   = '0;
              stored_count_next = '0;
              if (found) begin
                align_offset_next = found_off;
                phase_next        = (found_off == 3'd0) ? PH_RECORD : PH_OFFSET;
              end
            end
          end
          PH_OFFSET: begin
            if (n < {14'd0, align_offset}) begin
              byte_count_next = n[15:0];
            end else begin
              byte_count_next = '0;
              phase_next      = PH_RECORD;
            end
          end
          PH_RECORD: begin
            win_we = 32'(byte_count) < PACKET_BYTES;
            if (n < 17'(PACKET_BYTES)) begin
              byte_count_next = n[15:0];
            end else begin
              byte_count_next = '0;
              phase_next      = PH_SKIP;
              if (cmd.rx_byte != 8'd0 && window[3] != 8'd0) begin
                pend_angle_next   = {window[2], window[1][7:1]};
                pend_dist_next    = {cmd.rx_byte, window[3]};
                pending_flag_next = 1'b1;
              end
            end
          end
          PH_SKIP: begin
            if (pending_flag) begin
              pending_flag_next = 1'b0;
              in_range = pend_angle >= min_angle && pend_angle <= max_angle
                      && stored_count < limit;
              if (in_range) begin
                r.point_valid     = 1'b1;
                r.angle_raw       = pend_angle;
                r.distance_raw    = pend_dist;
                r.point_index     = 10'(stored_count);
                stored_count_next = stored_count + CNT_W'(1);
              end
            end
            if (n < {9'd0, skip_bytes}) begin
              byte_count_next = n[15:0];
            end else begin
              byte_count_next = '0;
              if (stored_count_next >= limit) begin
                run_mode_next    = MODE_PROC;
                phase_next       = PH_HOLD;
                ignore_flag_next = 1'b0;
                r.frame_done     = 1'b1;
              end else begin
                phase_next = PH_RECORD;
              end
            end
          end
          default: begin
            if (n < {1'b0, wait_bytes}) begin
              byte_count_next = n[15:0];
            end else begin
              byte_count_next = '0;
              if (run_mode == MODE_READY) begin
                ignore_flag_next = 1'b1;
                run_mode_next    = MODE_REC;
                phase_next       = PH_FIND;
              end
            end
          end
        endcase
      end
      default: ;
    endcase

    r.recording = ignore_flag_next;
    r.mode      = run_mode_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_mode     <= MODE_IDLE;
      phase        <= PH_HOLD;
      byte_count   <= '0;
      align_offset <= '0;
      pending_flag <= 1'b0;
      stored_count <= '0;
      ignore_flag  <= 1'b0;
    end else if (cmd_fire) begin
      run_mode     <= run_mode_next;
      phase        <= phase_next;
      byte_count   <= byte_count_next;
      align_offset <= align_offset_next;
      pending_flag <= pending_flag_next;
      stored_count <= stored_count_next;
      ignore_flag  <= ignore_flag_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      pend_angle <= pend_angle_next;
      pend_dist  <= pend_dist_next;
      if (win_we) window[win_addr] <= cmd.rx_byte;
    end
  end

  // output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (cmd_fire) begin
      if (!out_valid || res_fire) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (res_fire) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_fire) begin
      if (!out_valid || res_fire) begin
        out_data <= r;
      end else begin
        skid_data <= r;
      end
    end else if (res_fire && skid_valid) begin
      out_data <= skid_data;
    end
  end

  assign res.valid        = out_valid;
  assign res.point_valid  = out_data.point_valid;
  assign res.angle_raw    = out_data.angle_raw;
  assign res.distance_raw = out_data.distance_raw;
  assign res.point_index  = out_data.point_index;
  assign res.frame_done   = out_data.frame_done;
  assign res.recording    = out_data.recording;
  assign res.mode         = out_data.mode;

endmodule

### design/lspa_checker.sv
// ----------------------------------------------------------------------------
// lspa_checker
// Port-level checks on result transfers and register write-back.
// ----------------------------------------------------------------------------
module lspa_checker
  import lspa_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic              point_valid,
  input logic [14:0]       angle_raw,
  input logic [15:0]       distance_raw,
  input logic [9:0]        point_index,
  input logic              frame_done,
  input logic              recording,
  input logic [1:0]        mode,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic              pready,
  input logic [ADDR_W-1:0] paddr,
  input logic [DATA_W-1:0] pwdata,
  input logic [DATA_W-1:0] prdata
);

  localparam logic [ADDR_W-1:0] WAIT_ADDR = ADDR_W'({REG_WAIT_BYTES, 2'b00});

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(point_valid)
      && $stable(angle_raw) && $stable(distance_raw) && $stable(point_index)
      && $stable(frame_done) && $stable(recording) && $stable(mode))
    else $error("result changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result presented after reset");

  a_point_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && point_valid && !frame_done |-> recording && mode == MODE_REC)
    else $error("point outside recording");

  a_done_mode: assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_done |-> !recording && mode == MODE_PROC)
    else $error("frame end without processing mode");

  a_cfg_readback: assert property (@(posedge clk)
    (!rst && psel && penable && pwrite && pready && paddr == WAIT_ADDR)
      ##1 (!rst && paddr == WAIT_ADDR)
      |-> prdata == {16'd0, $past(pwdata[15:0])})
    else $error("register write not read back");

endmodule

bind lidar_scan_packet_aligner lspa_checker u_lspa_checker (
  .clk          (clk),
  .rst          (rst),
  .res_valid    (res.valid),
  .res_ready    (res.ready),
  .point_valid  (res.point_valid),
  .angle_raw    (res.angle_raw),
  .distance_raw (res.distance_raw),
  .point_index  (res.point_index),
  .frame_done   (res.frame_done),
  .recording    (res.recording),
  .mode         (res.mode),
  .psel         (psel),
  .penable      (penable),
  .pwrite       (pwrite),
  .pready       (pready),
  .paddr        (paddr),
  .pwdata       (pwdata),
  .prdata       (prdata)
);
